// ===== hw/rtl/brbbt_pkg.sv =====
// brbbt_pkg: shared constants, opcodes and structs of the byte ring buffer
// used by every module of byte_ring_buffer_block_transfer but brbbt_ram; no dependencies
`default_nettype none

package brbbt_pkg;

  // storage geometry
  localparam int DEPTH     = 256;
  localparam int MAX_BURST = 64;
  localparam int MIN_SIZE  = 2;
  localparam int SIZE_MAX  = (DEPTH < 256) ? DEPTH : 256;
  localparam int PTR_W     = $clog2(SIZE_MAX);
  localparam int SIZE_W    = PTR_W + 1;

  // field widths
  localparam int DATA_W = 8;
  localparam int LEN_W  = 7;
  localparam int FILL_W = 8;
  localparam int CFG_W  = 9;
  localparam int CMP_W  = ((SIZE_W > LEN_W) ? SIZE_W : LEN_W) + 1;

  // command queue between front and back
  localparam int CQ_DEPTH = 2;
  localparam int CQ_PTR_W = $clog2(CQ_DEPTH);
  localparam int CQ_CNT_W = CQ_PTR_W + 1;

  // result queue at the output
  localparam int OQ_DEPTH = 4;
  localparam int OQ_PTR_W = $clog2(OQ_DEPTH);
  localparam int OQ_CNT_W = OQ_PTR_W + 1;

  typedef enum logic [1:0] {
    OP_WRITE = 2'd0,
    OP_READ  = 2'd1,
    OP_PEEK  = 2'd2,
    OP_CLEAR = 2'd3
  } op_t;

  typedef enum logic {
    ST_CMD,
    ST_RUN
  } back_state_t;

  typedef struct packed {
    op_t               op;
    logic [DATA_W-1:0] data;
    logic [LEN_W-1:0]  length;
    logic              burst_end;
    logic              len_over;
    logic              len_zero;
  } cmd_t;

  typedef struct packed {
    logic              status;
    logic [DATA_W-1:0] read_byte;
    logic              byte_valid;
    logic              run_last;
    logic [FILL_W-1:0] fill_level;
  } result_t;

endpackage

`default_nettype wire

// ===== hw/rtl/byte_ring_buffer_block_transfer.sv =====
// path: an accepted beat passes the command queue, pending result register and output queue
// throughput: one write byte, clear or short request per cycle while the output queue has room;
//   a read or peek of n bytes holds the execution unit for one store read per byte
// reset: synchronous on rst; pointers, burst state and queues empty, size 256;
//   byte store contents are undefined and never swept
// depends on brbbt_pkg, brbbt_front, brbbt_back, brbbt_outq, brbbt_ram
`default_nettype none

module byte_ring_buffer_block_transfer import brbbt_pkg::*; (
  input  wire logic              clk,
  input  wire logic              rst,
  // size register
  input  wire logic              cfg_write,
  input  wire logic [CFG_W-1:0]  buffer_size,
  // input beats
  input  wire logic              in_valid,
  output logic                   in_stall,
  input  wire logic [1:0]        op,
  input  wire logic [DATA_W-1:0] data,
  input  wire logic [LEN_W-1:0]  length,
  input  wire logic              burst_end,
  // result beats
  output logic                   out_valid,
  input  wire logic              out_stall,
  output logic                   status,
  output logic [DATA_W-1:0]      read_byte,
  output logic                   byte_valid,
  output logic                   run_last,
  output logic [FILL_W-1:0]      fill_level
);

  // front to back command path
  logic                cmd_valid;
  cmd_t                cmd;
  logic                cmd_pop;

  // back to output queue
  logic                res_push;
  result_t             res;
  logic [OQ_CNT_W-1:0] oq_count;
  result_t             head_res;

  // front: takes input beats, tags length faults, queues two commands
  brbbt_front u_front (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .op        (op),
    .data      (data),
    .length    (length),
    .burst_end (burst_end),
    .cmd_pop   (cmd_pop),
    .cmd_valid (cmd_valid),
    .cmd       (cmd)
  );

  // back: owns the pointers and the byte store, runs bursts and read runs;
  // it only issues a result when the output queue has a guaranteed slot
  brbbt_back u_back (
    .clk       (clk),
    .rst       (rst),
    .cfg_write (cfg_write),
    .cfg_data  (buffer_size),
    .cmd_valid (cmd_valid),
    .cmd       (cmd),
    .cmd_pop   (cmd_pop),
    .oq_count  (oq_count),
    .res_push  (res_push),
    .res       (res)
  );

  // output queue: absorbs store read latency and downstream stall
  brbbt_outq u_outq (
    .clk        (clk),
    .rst        (rst),
    .push       (res_push),
    .push_res   (res),
    .pop        (out_valid && !out_stall),
    .count      (oq_count),
    .head_valid (out_valid),
    .head_res   (head_res)
  );

  assign status     = head_res.status;
  assign read_byte  = head_res.read_byte;
  assign byte_valid = head_res.byte_valid;
  assign run_last   = head_res.run_last;
  assign fill_level = head_res.fill_level;

endmodule

`default_nettype wire

// ===== hw/rtl/brbbt_ram.sv =====
// brbbt_ram: generic one-write one-read ram with registered read data
// no package dependencies
`default_nettype none

module brbbt_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 256
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic                     re,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

`default_nettype wire

// ===== hw/rtl/brbbt_front.sv =====
// brbbt_front: input beat acceptance, classification and command queue
// depends on brbbt_pkg
`default_nettype none

module brbbt_front import brbbt_pkg::*; (
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire logic              in_valid,
  output logic                   in_stall,
  input  wire logic [1:0]        op,
  input  wire logic [DATA_W-1:0] data,
  input  wire logic [LEN_W-1:0]  length,
  input  wire logic              burst_end,
  input  wire logic              cmd_pop,
  output logic                   cmd_valid,
  output cmd_t                   cmd
);

  cmd_t                q [CQ_DEPTH];
  logic [CQ_PTR_W-1:0] wr_ptr;
  logic [CQ_PTR_W-1:0] rd_ptr;
  logic [CQ_CNT_W-1:0] count;
  cmd_t                cls;
  logic                push;

  // classify the incoming beat
  always_comb begin
    cls.op        = op_t'(op);
    cls.data      = data;
    cls.length    = length;
    cls.burst_end = burst_end;
    cls.len_over  = length > LEN_W'(MAX_BURST);
    cls.len_zero  = length == '0;
  end

  assign in_stall  = count == CQ_CNT_W'(CQ_DEPTH);
  assign push      = in_valid && !in_stall;
  assign cmd_valid = count != '0;
  assign cmd       = q[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      q[wr_ptr] <= cls;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= wr_ptr + CQ_PTR_W'(1);
      end
      if (cmd_pop) begin
        rd_ptr <= rd_ptr + CQ_PTR_W'(1);
      end
      count <= count + CQ_CNT_W'(push) - CQ_CNT_W'(cmd_pop);
    end
  end

endmodule

`default_nettype wire

// ===== hw/rtl/brbbt_back.sv =====
// brbbt_back: command execution, pointers, burst tracking, byte store
// depends on brbbt_pkg and brbbt_ram
`default_nettype none

module brbbt_back import brbbt_pkg::*; (
  input  wire logic                clk,
  input  wire logic                rst,
  input  wire logic                cfg_write,
  input  wire logic [CFG_W-1:0]    cfg_data,
  input  wire logic                cmd_valid,
  input  wire cmd_t                cmd,
  output logic                     cmd_pop,
  input  wire logic [OQ_CNT_W-1:0] oq_count,
  output logic                     res_push,
  output result_t                  res
);

  back_state_t       state, state_next;
  logic [SIZE_W-1:0] size, size_next;
  logic [PTR_W-1:0]  wp, wp_next;
  logic [PTR_W-1:0]  rp, rp_next;
  logic              burst_active, burst_active_next;
  logic              burst_rejected, burst_rejected_next;
  logic [LEN_W-1:0]  burst_offset, burst_offset_next;
  logic [LEN_W-1:0]  burst_len, burst_len_next;
  logic [PTR_W-1:0]  run_ptr, run_ptr_next;
  logic [LEN_W-1:0]  run_left, run_left_next;
  logic [PTR_W-1:0]  run_fill, run_fill_next;
  logic              run_read, run_read_next;

  logic              pend_v;
  result_t           pend_res;
  logic              pend_mem;

  logic [SIZE_W-1:0] fill_w;
  logic [PTR_W-1:0]  fill;
  logic [CMP_W-1:0]  space;
  logic              issue_ok;
  logic [PTR_W-1:0]  rp_inc;
  logic [PTR_W-1:0]  run_ptr_inc;

  logic              b_rej;
  logic [LEN_W-1:0]  b_len;
  logic [LEN_W-1:0]  b_off;
  logic              b_store;
  logic [LEN_W-1:0]  b_off_new;
  logic [CMP_W-1:0]  waddr_sum;
  logic [PTR_W-1:0]  waddr;
  logic [CMP_W-1:0]  commit_sum;
  logic [PTR_W-1:0]  wp_commit;
  logic [FILL_W-1:0] fill_commit;
  logic [CFG_W-1:0]  size_clamped;

  logic              iss_v;
  result_t           iss_res;
  logic              iss_mem;
  logic              is_read;
  logic [PTR_W-1:0]  rd_cur;
  logic              ram_we;
  logic              ram_re;
  logic [PTR_W-1:0]  ram_raddr;
  logic [DATA_W-1:0] ram_rdata;

  function automatic logic [PTR_W-1:0] wrap_inc(input logic [PTR_W-1:0]  p,
                                                input logic [SIZE_W-1:0] s);
    logic [SIZE_W-1:0] sum;
    sum = SIZE_W'(p) + SIZE_W'(1);
    return (sum == s) ? '0 : sum[PTR_W-1:0];
  endfunction

  // occupancy and free slots, one slot always kept empty
  always_comb begin
    if (wp >= rp) begin
      fill_w = SIZE_W'(wp) - SIZE_W'(rp);
    end else begin
      fill_w = SIZE_W'(wp) + size - SIZE_W'(rp);
    end
    fill  = fill_w[PTR_W-1:0];
    space = CMP_W'(size) - CMP_W'(fill) - CMP_W'(1);
  end

  assign issue_ok    = (oq_count + OQ_CNT_W'(pend_v)) < OQ_CNT_W'(OQ_DEPTH);
  assign rp_inc      = wrap_inc(rp, size);
  assign run_ptr_inc = wrap_inc(run_ptr, size);

  // write burst bookkeeping for the current beat
  always_comb begin
    if (!burst_active) begin
      b_rej = cmd.len_over || (CMP_W'(cmd.length) > space);
      b_len = cmd.length;
      b_off = '0;
    end else begin
      b_rej = burst_rejected;
      b_len = burst_len;
      b_off = burst_offset;
    end
    b_store   = !b_rej && (b_off < b_len);
    b_off_new = b_store ? b_off + LEN_W'(1) : b_off;

    waddr_sum = CMP_W'(wp) + CMP_W'(b_off);
    if (waddr_sum >= CMP_W'(size)) begin
      waddr_sum = waddr_sum - CMP_W'(size);
    end
    waddr = waddr_sum[PTR_W-1:0];

    commit_sum = CMP_W'(wp) + CMP_W'(b_off_new);
    if (commit_sum >= CMP_W'(size)) begin
      commit_sum = commit_sum - CMP_W'(size);
    end
    wp_commit   = commit_sum[PTR_W-1:0];
    // an accepted burst always fits, so the fill simply grows by its bytes
    fill_commit = FILL_W'(CMP_W'(fill) + CMP_W'(b_off_new));
  end

  // size register clamp
  always_comb begin
    if (cfg_data < CFG_W'(MIN_SIZE)) begin
      size_clamped = CFG_W'(MIN_SIZE);
    end else if (cfg_data > CFG_W'(SIZE_MAX)) begin
      size_clamped = CFG_W'(SIZE_MAX);
    end else begin
      size_clamped = cfg_data;
    end
  end

  always_comb begin
    state_next          = state;
    size_next           = size;
    wp_next             = wp;
    rp_next             = rp;
    burst_active_next   = burst_active;
    burst_rejected_next = burst_rejected;
    burst_offset_next   = burst_offset;
    burst_len_next      = burst_len;
    run_ptr_next        = run_ptr;
    run_left_next       = run_left;
    run_fill_next       = run_fill;
    run_read_next       = run_read;
    cmd_pop             = 1'b0;
    iss_v               = 1'b0;
    iss_res             = '0;
    iss_mem             = 1'b0;
    is_read             = 1'b0;
    rd_cur              = fill;
    ram_we              = 1'b0;
    ram_re              = 1'b0;
    ram_raddr           = rp;

    case (state)
      ST_CMD: begin
        if (cmd_valid && issue_ok) begin
          cmd_pop = 1'b1;
          case (cmd.op)
            OP_WRITE: begin
              burst_active_next   = 1'b1;
              burst_rejected_next = b_rej;
              burst_offset_next   = b_off_new;
              burst_len_next      = b_len;
              ram_we              = b_store;
              if (cmd.burst_end) begin
                iss_v               = 1'b1;
                iss_res.status      = b_rej;
                iss_res.run_last    = 1'b1;
                iss_res.fill_level  = b_rej ? FILL_W'(fill) : fill_commit;
                if (!b_rej) begin
                  wp_next = wp_commit;
                end
                burst_active_next   = 1'b0;
                burst_rejected_next = 1'b0;
                burst_offset_next   = '0;
                burst_len_next      = '0;
              end
            end
            OP_CLEAR: begin
              wp_next = '0;
              rp_next = '0;
              if (burst_active) begin
                burst_rejected_next = 1'b1;
              end
              iss_v            = 1'b1;
              iss_res.run_last = 1'b1;
            end
            OP_READ, OP_PEEK: begin
              is_read = cmd.op == OP_READ;
              if (cmd.len_over || (CMP_W'(cmd.length) > CMP_W'(fill))) begin
                // not enough stored data, or length over the burst limit
                iss_v              = 1'b1;
                iss_res.status     = 1'b1;
                iss_res.run_last   = 1'b1;
                iss_res.fill_level = FILL_W'(fill);
              end else if (cmd.len_zero) begin
                iss_v              = 1'b1;
                iss_res.run_last   = 1'b1;
                iss_res.fill_level = FILL_W'(fill);
              end else begin
                rd_cur             = is_read ? fill - PTR_W'(1) : fill;
                iss_v              = 1'b1;
                iss_mem            = 1'b1;
                ram_re             = 1'b1;
                ram_raddr          = rp;
                iss_res.byte_valid = 1'b1;
                iss_res.run_last   = cmd.length == LEN_W'(1);
                iss_res.fill_level = FILL_W'(rd_cur);
                if (cmd.length == LEN_W'(1)) begin
                  if (is_read) begin
                    rp_next = rp_inc;
                  end
                end else begin
                  state_next    = ST_RUN;
                  run_ptr_next  = rp_inc;
                  run_left_next = cmd.length - LEN_W'(1);
                  run_fill_next = rd_cur;
                  run_read_next = is_read;
                end
              end
            end
            default: ;
          endcase
        end
      end
      ST_RUN: begin
        if (issue_ok) begin
          rd_cur             = run_read ? run_fill - PTR_W'(1) : run_fill;
          iss_v              = 1'b1;
          iss_mem            = 1'b1;
          ram_re             = 1'b1;
          ram_raddr          = run_ptr;
          iss_res.byte_valid = 1'b1;
          iss_res.run_last   = run_left == LEN_W'(1);
          iss_res.fill_level = FILL_W'(rd_cur);
          run_ptr_next       = run_ptr_inc;
          run_left_next      = run_left - LEN_W'(1);
          run_fill_next      = rd_cur;
          if (run_left == LEN_W'(1)) begin
            state_next = ST_CMD;
            if (run_read) begin
              rp_next = run_ptr_inc;
            end
          end
        end
      end
      default: state_next = ST_CMD;
    endcase

    // size write empties the ring and spoils an open burst
    if (cfg_write) begin
      size_next = SIZE_W'(size_clamped);
      wp_next   = '0;
      rp_next   = '0;
      if (burst_active) begin
        burst_rejected_next = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state          <= ST_CMD;
      size           <= SIZE_W'(SIZE_MAX);
      wp             <= '0;
      rp             <= '0;
      burst_active   <= 1'b0;
      burst_rejected <= 1'b0;
      burst_offset   <= '0;
      burst_len      <= '0;
      pend_v         <= 1'b0;
    end else begin
      state          <= state_next;
      size           <= size_next;
      wp             <= wp_next;
      rp             <= rp_next;
      burst_active   <= burst_active_next;
      burst_rejected <= burst_rejected_next;
      burst_offset   <= burst_offset_next;
      burst_len      <= burst_len_next;
      pend_v         <= iss_v;
    end
  end

  always_ff @(posedge clk) begin
    run_ptr  <= run_ptr_next;
    run_left <= run_left_next;
    run_fill <= run_fill_next;
    run_read <= run_read_next;
    pend_res <= iss_res;
    pend_mem <= iss_mem;
  end

  brbbt_ram #(
    .WIDTH (DATA_W),
    .DEPTH (SIZE_MAX)
  ) u_store (
    .clk   (clk),
    .we    (ram_we),
    .waddr (waddr),
    .wdata (cmd.data),
    .re    (ram_re),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  always_comb begin
    res_push      = pend_v;
    res           = pend_res;
    res.read_byte = pend_mem ? ram_rdata : '0;
  end

endmodule

`default_nettype wire

// ===== hw/rtl/brbbt_outq.sv =====
// brbbt_outq: small result queue that decouples the back end from out_stall
// depends on brbbt_pkg
`default_nettype none

module brbbt_outq import brbbt_pkg::*; (
  input  wire logic                clk,
  input  wire logic                rst,
  input  wire logic                push,
  input  wire result_t             push_res,
  input  wire logic                pop,
  output logic [OQ_CNT_W-1:0]      count,
  output logic                     head_valid,
  output result_t                  head_res
);

  result_t             q [OQ_DEPTH];
  logic [OQ_PTR_W-1:0] wr_ptr;
  logic [OQ_PTR_W-1:0] rd_ptr;

  assign head_valid = count != '0;
  assign head_res   = q[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      q[wr_ptr] <= push_res;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= wr_ptr + OQ_PTR_W'(1);
      end
      if (pop) begin
        rd_ptr <= rd_ptr + OQ_PTR_W'(1);
      end
      count <= count + OQ_CNT_W'(push) - OQ_CNT_W'(pop);
    end
  end

endmodule

`default_nettype wire

// ===== hw/rtl/brbbt_checker.sv =====
// brbbt_checker: port-level assertions for byte_ring_buffer_block_transfer
// depends on brbbt_pkg; bound to the top level at the end of this file
`default_nettype none

module brbbt_checker import brbbt_pkg::*; (
  input wire logic              clk,
  input wire logic              rst,
  input wire logic              out_valid,
  input wire logic              out_stall,
  input wire logic              status,
  input wire logic [DATA_W-1:0] read_byte,
  input wire logic              byte_valid,
  input wire logic              run_last
);

  // a stalled result beat stays offered
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=> out_valid)
    else $error("result beat dropped while stalled");

  // a byte beat is never a failure
  a_byte_ok: assert property (@(posedge clk) disable iff (rst)
    out_valid && byte_valid |-> !status)
    else $error("byte beat carries reject status");

  // a reject ends its run at once and carries no byte
  a_reject_single: assert property (@(posedge clk) disable iff (rst)
    out_valid && status |-> run_last && !byte_valid && (read_byte == '0))
    else $error("reject beat is not a lone status beat");

  // status beats carry a zero byte and end their run
  a_status_zero: assert property (@(posedge clk) disable iff (rst)
    out_valid && !byte_valid |-> run_last && (read_byte == '0))
    else $error("status beat carries byte data or continues a run");

endmodule

bind byte_ring_buffer_block_transfer brbbt_checker u_brbbt_checker (.*);

`default_nettype wire
